// ===== hdl/ptlk_pkg.sv =====
package ptlk_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int NORM_STEPS   = 6;
  localparam int NORM_TOP     = 41;
  localparam int ROT_W        = 33;
  localparam int VEC_W        = 48;
  localparam int TURN_W       = 32;
  localparam int LINK_W       = 20;
  localparam int ROOT_W       = 64;

  typedef logic signed [ROT_W-1:0] rot_t;
  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic [TURN_W-1:0]       turn_t;
  typedef logic [VEC_W-1:0]        mag_t;
  typedef logic [ROOT_W-1:0]       root_t;

  localparam rot_t  CORDIC_INV_GAIN = 33'sd652032874;
  localparam turn_t HALF_TURN       = 32'h8000_0000;

  localparam logic [29:0] TURN_ATAN [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051D, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2E,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2F9,
    30'h0000517C, 30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
    30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051, 30'h00000028,
    30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000002, 30'h00000001
  };

endpackage

// ===== hdl/ptlk_rot_cell.sv =====
module ptlk_rot_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          adv,
  input  ptlk_pkg::rot_t x_in,
  input  ptlk_pkg::rot_t y_in,
  input  ptlk_pkg::rot_t z_in,
  output ptlk_pkg::rot_t x_out,
  output ptlk_pkg::rot_t y_out,
  output ptlk_pkg::rot_t z_out
);
  import ptlk_pkg::*;

  rot_t dx;
  rot_t dy;
  rot_t atan_step;

  assign dx        = y_in >>> STEP;
  assign dy        = x_in >>> STEP;
  assign atan_step = $signed({3'b000, TURN_ATAN[STEP]});

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!z_in[ROT_W-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - atan_step;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + atan_step;
      end
    end
  end

endmodule

// ===== hdl/ptlk_sqrt_cell.sv =====
module ptlk_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           adv,
  input  ptlk_pkg::root_t v_in,
  input  ptlk_pkg::root_t r_in,
  output ptlk_pkg::root_t v_out,
  output ptlk_pkg::root_t r_out
);
  import ptlk_pkg::*;

  localparam root_t BIT = root_t'(1) << (62 - 2 * STEP);

  root_t trial;

  assign trial = r_in + BIT;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (v_in >= trial) begin
        v_out <= v_in - trial;
        r_out <= (r_in >> 1) + BIT;
      end else begin
        v_out <= v_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule

// ===== hdl/ptlk_norm_cell.sv =====
module ptlk_norm_cell #(
  parameter int SHIFT = 1
) (
  input  logic           clk,
  input  logic           adv,
  input  ptlk_pkg::vec_t  x_in,
  input  ptlk_pkg::vec_t  y_in,
  input  ptlk_pkg::turn_t z_in,
  input  ptlk_pkg::mag_t  m_in,
  output ptlk_pkg::vec_t  x_out,
  output ptlk_pkg::vec_t  y_out,
  output ptlk_pkg::turn_t z_out,
  output ptlk_pkg::mag_t  m_out
);
  import ptlk_pkg::*;

  localparam mag_t LIMIT = mag_t'(1) << (NORM_TOP - SHIFT);

  always_ff @(posedge clk) begin
    if (adv) begin
      z_out <= z_in;
      if (m_in < LIMIT) begin
        x_out <= x_in <<< SHIFT;
        y_out <= y_in <<< SHIFT;
        m_out <= m_in << SHIFT;
      end else begin
        x_out <= x_in;
        y_out <= y_in;
        m_out <= m_in;
      end
    end
  end

endmodule

// ===== hdl/ptlk_vec_cell.sv =====
module ptlk_vec_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           adv,
  input  ptlk_pkg::vec_t  x_in,
  input  ptlk_pkg::vec_t  y_in,
  input  ptlk_pkg::turn_t z_in,
  output ptlk_pkg::vec_t  x_out,
  output ptlk_pkg::vec_t  y_out,
  output ptlk_pkg::turn_t z_out
);
  import ptlk_pkg::*;

  vec_t  dx;
  vec_t  dy;
  turn_t atan_step;

  assign dx        = y_in >>> STEP;
  assign dy        = x_in >>> STEP;
  assign atan_step = {2'b00, TURN_ATAN[STEP]};

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!y_in[VEC_W-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + atan_step;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - atan_step;
      end
    end
  end

endmodule

// ===== hdl/planar_three_link_kinematics.sv =====
// Planar three-link arm kinematics.
// Input channel (in_valid/in_ready): cmd selects forward (joint angles to tip
// position and heading) or inverse (tip position and heading to joint angles).
// Output channel (out_valid/out_ready): one result per input transfer, in order;
// fields unused by the command are zero, status flags an unreachable pose.
// Link lengths sit in three registers on the APB port at byte addresses 0, 4, 8;
// write them only while no transfer is in flight.
// Throughput: one transfer per cycle while the output is not stalled. Each transfer
// passes through the chain of 30 rotation cells, the six arithmetic stages,
// 32 square-root cells, six normalising cells and 30 vectoring cells.
// The whole chain advances whenever the output register is empty or being taken;
// while the receiver stalls with a result waiting, the chain and in_ready hold.
// Synchronous reset empties the chain, drops out_valid and restores the link
// lengths to 100.0, 100.0 and 50.0.
module planar_three_link_kinematics #(
  parameter int ANGLE_BITS = 16,
  parameter int POS_BITS   = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  input  logic signed [ANGLE_BITS-1:0] joint1_angle,
  input  logic signed [ANGLE_BITS-1:0] joint2_angle,
  input  logic signed [ANGLE_BITS-1:0] joint3_angle,
  input  logic signed [POS_BITS-1:0]   pos_x,
  input  logic signed [POS_BITS-1:0]   pos_y,
  input  logic signed [ANGLE_BITS-1:0] heading,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ANGLE_BITS-1:0] out_joint1,
  output logic signed [ANGLE_BITS-1:0] out_joint2,
  output logic signed [ANGLE_BITS-1:0] out_joint3,
  output logic signed [POS_BITS-1:0]   out_x,
  output logic signed [POS_BITS-1:0]   out_y,
  output logic signed [ANGLE_BITS-1:0] out_heading,
  output logic                         status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ptlk_pkg::*;

  localparam int WB       = (POS_BITS > 21 ? POS_BITS : 21) + 2;
  localparam int ROT_END  = CORDIC_STEPS;
  localparam int ST_PROD  = ROT_END + 1;
  localparam int ST_WR    = ROT_END + 2;
  localparam int ST_SQ    = ROT_END + 3;
  localparam int ST_C1    = ROT_END + 4;
  localparam int ST_C2    = ROT_END + 5;
  localparam int ST_M     = ROT_END + 6;
  localparam int SQ_END   = ST_M + SQRT_STEPS;
  localparam int ST_AP    = SQ_END + 1;
  localparam int VEC_LAST = NORM_STEPS + CORDIC_STEPS;
  localparam int LAST     = ST_AP + VEC_LAST;

  localparam logic [1:0] REG_LINK1 = 2'd0;
  localparam logic [1:0] REG_LINK2 = 2'd1;
  localparam logic [1:0] REG_LINK3 = 2'd2;

  localparam logic [LINK_W-1:0] LINK1_RESET = 20'd25600;
  localparam logic [LINK_W-1:0] LINK2_RESET = 20'd25600;
  localparam logic [LINK_W-1:0] LINK3_RESET = 20'd12800;

  localparam logic signed [55:0] RND  = 56'sd536870912;
  localparam logic signed [55:0] PMAX = (56'sd1 <<< (POS_BITS - 1)) - 56'sd1;
  localparam logic signed [55:0] PMIN = -(56'sd1 <<< (POS_BITS - 1));
  localparam logic [40:0]        DEN_LIM = 41'd1 << 30;

  typedef struct packed {
    logic                         cmd;
    turn_t                        h;
    logic [ANGLE_BITS-1:0]        fhd;
    logic signed [POS_BITS-1:0]   px;
    logic signed [POS_BITS-1:0]   py;
    logic signed [POS_BITS-1:0]   fx;
    logic signed [POS_BITS-1:0]   fy;
    logic [2:0]                   flip;
    logic signed [WB-1:0]         wx;
    logic signed [WB-1:0]         wy;
    logic [63:0]                  w2;
    logic                         unr;
    logic signed [45:0]           num;
    logic [45:0]                  cb;
    logic signed [31:0]           nn;
    mag_t                         cc;
    logic [2:0]                   zero;
  } ctx_t;

  function automatic logic [ANGLE_BITS-1:0] ang_out(input turn_t z);
    turn_t r;
    r = z + (turn_t'(1) << (31 - ANGLE_BITS));
    return r[TURN_W-1 -: ANGLE_BITS];
  endfunction

  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [55:0] v);
    logic signed [55:0] c;
    c = v;
    if (v > PMAX) c = PMAX;
    else if (v < PMIN) c = PMIN;
    return c[POS_BITS-1:0];
  endfunction

  // configuration registers and values derived from them
  logic [LINK_W-1:0] link1_length, link2_length, link3_length;
  logic [39:0]       l1sq, l2sq, difsq;
  logic [41:0]       sumsq;
  logic [40:0]       den;
  logic [3:0]        sh, sh_next;
  logic [29:0]       dd;
  logic [LINK_W-1:0] ldif;
  logic [LINK_W:0]   lsum;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link1_length <= LINK1_RESET;
      link2_length <= LINK2_RESET;
      link3_length <= LINK3_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_LINK1: link1_length <= pwdata[LINK_W-1:0];
        REG_LINK2: link2_length <= pwdata[LINK_W-1:0];
        REG_LINK3: link3_length <= pwdata[LINK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LINK1: prdata = 32'(link1_length);
      REG_LINK2: prdata = 32'(link2_length);
      REG_LINK3: prdata = 32'(link3_length);
      default:   prdata = '0;
    endcase
  end

  assign ldif = (link1_length > link2_length) ? link1_length - link2_length
                                               : link2_length - link1_length;
  assign lsum = {1'b0, link1_length} + {1'b0, link2_length};

  always_comb begin
    sh_next = '0;
    for (int k = 0; k < 11; k++) begin
      if ((den >> k) >= DEN_LIM) sh_next = 4'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    l1sq  <= 40'(link1_length) * 40'(link1_length);
    l2sq  <= 40'(link2_length) * 40'(link2_length);
    difsq <= 40'(ldif) * 40'(ldif);
    sumsq <= 42'(lsum) * 42'(lsum);
    den   <= {40'(link1_length) * 40'(link2_length), 1'b0};
    sh    <= sh_next;
    dd    <= 30'(den >> sh_next);
  end

  // chain control
  logic       adv;
  logic [LAST:0] vld;
  ctx_t       ctx_q [0:LAST];
  ctx_t       ctx_d [0:LAST];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[LAST-1:0], in_valid};
      out_valid <= vld[LAST];
    end
  end

  // entry: lane angles for the rotation chain
  turn_t a1, hh;
  turn_t ang [3];
  turn_t azs [3];
  logic [2:0] fl;
  rot_t rx [3][CORDIC_STEPS+1];
  rot_t ry [3][CORDIC_STEPS+1];
  rot_t rz [3][CORDIC_STEPS+1];
  rot_t rx0 [3];
  rot_t ry0 [3];
  rot_t rz0 [3];

  assign a1 = {joint1_angle, {(TURN_W-ANGLE_BITS){1'b0}}};
  assign hh = {heading, {(TURN_W-ANGLE_BITS){1'b0}}};

  always_comb begin
    ang[0] = cmd ? hh : a1;
    ang[1] = a1 + {joint2_angle, {(TURN_W-ANGLE_BITS){1'b0}}} + HALF_TURN;
    ang[2] = a1 + {joint3_angle, {(TURN_W-ANGLE_BITS){1'b0}}} + HALF_TURN;
    for (int l = 0; l < 3; l++) begin
      fl[l]  = ang[l][31] ^ ang[l][30];
      azs[l] = fl[l] ? ang[l] + HALF_TURN : ang[l];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        rx0[l] <= CORDIC_INV_GAIN;
        ry0[l] <= '0;
        rz0[l] <= $signed({azs[l][31], azs[l]});
      end
    end
  end

  // products of link lengths with cos and sin
  logic signed [53:0] pxr [3];
  logic signed [53:0] pyr [3];
  logic signed [53:0] pxc [3];
  logic signed [53:0] pyc [3];
  logic signed [LINK_W:0] llen [3];
  rot_t cv [3];
  rot_t sv [3];

  always_comb begin
    llen[0] = $signed({1'b0, ctx_q[ROT_END].cmd ? link3_length : link1_length});
    llen[1] = $signed({1'b0, link2_length});
    llen[2] = $signed({1'b0, link3_length});
    for (int l = 0; l < 3; l++) begin
      cv[l]  = ctx_q[ROT_END].flip[l] ? -rx[l][ROT_END] : rx[l][ROT_END];
      sv[l]  = ctx_q[ROT_END].flip[l] ? -ry[l][ROT_END] : ry[l][ROT_END];
      pxc[l] = 54'(llen[l]) * 54'(cv[l]);
      pyc[l] = 54'(llen[l]) * 54'(sv[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        pxr[l] <= pxc[l];
        pyr[l] <= pyc[l];
      end
    end
  end

  // square root chain
  root_t sqv [SQRT_STEPS+1];
  root_t sqr [SQRT_STEPS+1];
  root_t sq_prod;
  logic [32:0] fa, fb;

  assign fa      = $signed({3'b000, dd}) - 33'(ctx_q[ST_C2].nn);
  assign fb      = $signed({3'b000, dd}) + 33'(ctx_q[ST_C2].nn);
  assign sq_prod = root_t'(fa[31:0]) * root_t'(fb[31:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      sqv[0] <= sq_prod;
      sqr[0] <= '0;
    end
  end

  // vectoring lanes: 0 gives q2, 1 gives the asin term, 2 the wrist bearing
  vec_t  vxi [3];
  vec_t  vyi [3];
  vec_t  vxa [3];
  vec_t  vya [3];
  vec_t  vay [3];
  logic [2:0] vneg, vzero;
  mag_t  vm [3];
  vec_t  qx [3][VEC_LAST+1];
  vec_t  qy [3][VEC_LAST+1];
  turn_t qz [3][VEC_LAST+1];
  mag_t  qm [3][NORM_STEPS+1];

  always_comb begin
    vyi[0] = vec_t'(sqr[SQRT_STEPS][31:0]);
    vxi[0] = vec_t'(ctx_q[SQ_END].nn);
    vyi[1] = vec_t'(sqr[SQRT_STEPS][31:0]);
    vxi[1] = vec_t'(ctx_q[SQ_END].cc);
    vyi[2] = vec_t'(ctx_q[SQ_END].wy);
    vxi[2] = vec_t'(ctx_q[SQ_END].wx);
    for (int l = 0; l < 3; l++) begin
      vneg[l]  = vxi[l][VEC_W-1];
      vxa[l]   = vneg[l] ? -vxi[l] : vxi[l];
      vya[l]   = vneg[l] ? -vyi[l] : vyi[l];
      vay[l]   = vya[l][VEC_W-1] ? -vya[l] : vya[l];
      vm[l]    = (vxa[l] > vay[l]) ? mag_t'(vxa[l]) : mag_t'(vay[l]);
      vzero[l] = (vm[l] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        qx[l][0] <= vxa[l];
        qy[l][0] <= vya[l];
        qz[l][0] <= vneg[l] ? HALF_TURN : '0;
        qm[l][0] <= vm[l];
      end
    end
  end

  // side information along the chain
  logic signed [55:0] sxs, sys, wxv, wyv;
  logic [WB-1:0]      ux, uy;
  logic signed [45:0] tcb, ns, dds;

  always_comb begin
    ctx_d[0]      = '0;
    ctx_d[0].cmd  = cmd;
    ctx_d[0].h    = hh;
    ctx_d[0].fhd  = ang_out(ang[2]);
    ctx_d[0].px   = pos_x;
    ctx_d[0].py   = pos_y;
    ctx_d[0].flip = fl;
    for (int s = 1; s <= LAST; s++) ctx_d[s] = ctx_q[s-1];

    sxs = (56'(pxr[0]) + 56'(pxr[1]) + 56'(pxr[2]) + RND) >>> 30;
    sys = (56'(pyr[0]) + 56'(pyr[1]) + 56'(pyr[2]) + RND) >>> 30;
    wxv = 56'(ctx_q[ST_PROD].px) - ((56'(pxr[0]) + RND) >>> 30);
    wyv = 56'(ctx_q[ST_PROD].py) - ((56'(pyr[0]) + RND) >>> 30);
    ctx_d[ST_WR].fx = sat_pos(sxs);
    ctx_d[ST_WR].fy = sat_pos(sys);
    ctx_d[ST_WR].wx = WB'(wxv);
    ctx_d[ST_WR].wy = WB'(wyv);

    ux = ctx_q[ST_WR].wx[WB-1] ? -ctx_q[ST_WR].wx : ctx_q[ST_WR].wx;
    uy = ctx_q[ST_WR].wy[WB-1] ? -ctx_q[ST_WR].wy : ctx_q[ST_WR].wy;
    ctx_d[ST_SQ].w2 = 64'(ux) * 64'(ux) + 64'(uy) * 64'(uy);

    ctx_d[ST_C1].unr = (link1_length == '0) || (link2_length == '0) ||
                       (ctx_q[ST_SQ].w2 == '0) || (ctx_q[ST_SQ].w2 > 64'(sumsq)) ||
                       (ctx_q[ST_SQ].w2 < 64'(difsq));
    ctx_d[ST_C1].num = $signed({6'b0, l1sq}) + $signed({6'b0, l2sq})
                       - $signed({1'b0, ctx_q[ST_SQ].w2[44:0]});
    tcb = $signed({6'b0, l1sq}) + $signed({1'b0, ctx_q[ST_SQ].w2[44:0]})
          - $signed({6'b0, l2sq});
    ctx_d[ST_C1].cb = tcb[45] ? 46'(-tcb) : 46'(tcb);

    ns  = ctx_q[ST_C1].num >>> sh;
    dds = $signed({16'b0, dd});
    if (ns > dds) ctx_d[ST_C2].nn = 32'(dds);
    else if (ns < -dds) ctx_d[ST_C2].nn = 32'(-dds);
    else ctx_d[ST_C2].nn = 32'(ns);
    ctx_d[ST_C2].cc = mag_t'(ctx_q[ST_C1].cb >> sh);

    ctx_d[ST_AP].zero = vzero;
  end

  always_ff @(posedge clk) begin
    if (adv) ctx_q <= ctx_d;
  end

  // cell chains
  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign rx[l][0] = rx0[l];
    assign ry[l][0] = ry0[l];
    assign rz[l][0] = rz0[l];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
      ptlk_rot_cell #(.STEP(k)) u_rot (
        .clk   (clk),
        .adv   (adv),
        .x_in  (rx[l][k]),
        .y_in  (ry[l][k]),
        .z_in  (rz[l][k]),
        .x_out (rx[l][k+1]),
        .y_out (ry[l][k+1]),
        .z_out (rz[l][k+1])
      );
    end

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
      ptlk_norm_cell #(.SHIFT(32 >> j)) u_norm (
        .clk   (clk),
        .adv   (adv),
        .x_in  (qx[l][j]),
        .y_in  (qy[l][j]),
        .z_in  (qz[l][j]),
        .m_in  (qm[l][j]),
        .x_out (qx[l][j+1]),
        .y_out (qy[l][j+1]),
        .z_out (qz[l][j+1]),
        .m_out (qm[l][j+1])
      );
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
      ptlk_vec_cell #(.STEP(k)) u_vec (
        .clk   (clk),
        .adv   (adv),
        .x_in  (qx[l][NORM_STEPS+k]),
        .y_in  (qy[l][NORM_STEPS+k]),
        .z_in  (qz[l][NORM_STEPS+k]),
        .x_out (qx[l][NORM_STEPS+k+1]),
        .y_out (qy[l][NORM_STEPS+k+1]),
        .z_out (qz[l][NORM_STEPS+k+1])
      );
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    ptlk_sqrt_cell #(.STEP(k)) u_sqrt (
      .clk   (clk),
      .adv   (adv),
      .v_in  (sqv[k]),
      .r_in  (sqr[k]),
      .v_out (sqv[k+1]),
      .r_out (sqr[k+1])
    );
  end

  // output register
  turn_t fz [3];
  turn_t q1, q3;
  ctx_t  cl;

  always_comb begin
    cl = ctx_q[LAST];
    for (int l = 0; l < 3; l++) fz[l] = cl.zero[l] ? '0 : qz[l][VEC_LAST];
    q1 = fz[2] + fz[1];
    q3 = HALF_TURN - q1 + cl.h;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cl.cmd) begin
        out_joint1  <= cl.unr ? '0 : ang_out(q1);
        out_joint2  <= cl.unr ? '0 : ang_out(fz[0]);
        out_joint3  <= cl.unr ? '0 : ang_out(q3);
        status      <= cl.unr;
        out_x       <= '0;
        out_y       <= '0;
        out_heading <= '0;
      end else begin
        out_joint1  <= '0;
        out_joint2  <= '0;
        out_joint3  <= '0;
        status      <= 1'b0;
        out_x       <= cl.fx;
        out_y       <= cl.fy;
        out_heading <= cl.fhd;
      end
    end
  end

endmodule

// ===== tb/sv/planar_three_link_kinematics_chk.sv =====
module planar_three_link_kinematics_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               cmd,
  input  logic signed [15:0] joint1_angle,
  input  logic signed [15:0] joint2_angle,
  input  logic signed [15:0] joint3_angle,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [15:0] heading,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_joint1,
  input  logic signed [15:0] out_joint2,
  input  logic signed [15:0] out_joint3,
  input  logic signed [23:0] out_x,
  input  logic signed [23:0] out_y,
  input  logic signed [15:0] out_heading,
  input  logic               status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fails,
  output int                 pending
);
  import ptlk_pkg::*;

  localparam logic [3:0] REG_LINK1 = 4'd0;
  localparam logic [3:0] REG_LINK2 = 4'd4;
  localparam logic [3:0] REG_LINK3 = 4'd8;
  localparam logic [3:0] REG_MASK  = 4'hc;
  localparam logic CMD_FWD = 1'b0;

  typedef struct packed {
    logic signed [15:0] j1, j2, j3;
    logic signed [23:0] x, y;
    logic signed [15:0] hd;
    logic               st;
  } pose_t;

  longint len1, len2, len3;
  pose_t  awaited[$];

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic turn_t to_turn(logic [15:0] a);
    return {a, 16'h0};
  endfunction

  function automatic logic [15:0] from_turn(turn_t z);
    turn_t r;
    r = z + 32'h0000_8000;
    return r[31:16];
  endfunction

  task automatic rotate(input turn_t a, output longint c, output longint s);
    longint x, y, z, dx, dy;
    logic flip;
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + HALF_TURN;
    z = longint'(signed'(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(TURN_ATAN[i]);
      end else begin
        x += dx; y -= dy; z += longint'(TURN_ATAN[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic turn_t bearing(longint y, longint x);
    turn_t z;
    longint m, ay, dx, dy;
    z = '0;
    if (x < 0) begin
      x = -x; y = -y; z = HALF_TURN;
    end
    ay = y < 0 ? -y : y;
    m = x > ay ? x : ay;
    if (m == 0) return '0;
    while (m < (64'sd1 <<< 40)) begin
      x *= 2; y *= 2; m *= 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z = z + turn_t'(TURN_ATAN[i]);
      end else begin
        x -= dx; y += dy; z = z - turn_t'(TURN_ATAN[i]);
      end
    end
    return z;
  endfunction

  function automatic logic [63:0] root(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [23:0] clamp(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  task automatic solve_pose(input logic c_in, input logic [15:0] a1i, a2i, a3i,
                            input logic signed [23:0] px, py, input logic [15:0] hi,
                            output pose_t p);
    longint c, s, sx, sy, wx, wy, w2, suml, difl, num, den, cb, dd, nn, cc;
    logic [63:0] sq;
    turn_t a1, a2, a3, h, q1, q2, q3, b;
    int sh;
    p = '0;
    if (c_in == CMD_FWD) begin
      a1 = to_turn(a1i); a2 = to_turn(a2i); a3 = to_turn(a3i);
      rotate(a1, c, s);
      sx = len1 * c; sy = len1 * s;
      rotate(a1 + a2 + HALF_TURN, c, s);
      sx += len2 * c; sy += len2 * s;
      rotate(a1 + a3 + HALF_TURN, c, s);
      sx += len3 * c; sy += len3 * s;
      p.x = clamp(shr(sx + (64'sd1 <<< 29), 30));
      p.y = clamp(shr(sy + (64'sd1 <<< 29), 30));
      p.hd = from_turn(a1 + a3 + HALF_TURN);
      return;
    end
    h = to_turn(hi);
    rotate(h, c, s);
    wx = longint'(px) - shr(len3 * c + (64'sd1 <<< 29), 30);
    wy = longint'(py) - shr(len3 * s + (64'sd1 <<< 29), 30);
    w2 = wx * wx + wy * wy;
    suml = len1 + len2;
    difl = len1 > len2 ? len1 - len2 : len2 - len1;
    if (len1 == 0 || len2 == 0 || w2 == 0 || w2 > suml * suml || w2 < difl * difl) begin
      p.st = 1'b1;
      return;
    end
    num = len1 * len1 + len2 * len2 - w2;
    den = 2 * len1 * len2;
    cb = len1 * len1 + w2 - len2 * len2;
    if (cb < 0) cb = -cb;
    sh = 0;
    while ((den >>> sh) >= (64'sd1 <<< 30)) sh++;
    dd = den >>> sh;
    nn = shr(num, sh);
    if (nn > dd) nn = dd;
    if (nn < -dd) nn = -dd;
    cc = cb >>> sh;
    sq = root(64'(dd - nn) * 64'(dd + nn));
    q2 = bearing(longint'(sq), nn);
    b = bearing(longint'(sq), cc);
    q1 = bearing(wy, wx) + b;
    q3 = HALF_TURN - q1 + h;
    p.j1 = from_turn(q1);
    p.j2 = from_turn(q2);
    p.j3 = from_turn(q3);
  endtask

  assign pending = awaited.size();

  always @(posedge clk) begin
    pose_t p, e, g;
    if (rst) begin
      len1 = 25600; len2 = 25600; len3 = 12800;
      awaited.delete();
      fails <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr & REG_MASK)
          REG_LINK1: len1 = pwdata[19:0];
          REG_LINK2: len2 = pwdata[19:0];
          REG_LINK3: len3 = pwdata[19:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        g = '{out_joint1, out_joint2, out_joint3, out_x, out_y, out_heading, status};
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result %h", $time, g);
          fails <= fails + 1;
        end else begin
          e = awaited.pop_front();
          if (e !== g) begin
            $display("%0t: mismatch expected j %0d %0d %0d x %0d y %0d h %0d st %0d",
                     $time, e.j1, e.j2, e.j3, e.x, e.y, e.hd, e.st);
            $display("%0t:          actual   j %0d %0d %0d x %0d y %0d h %0d st %0d",
                     $time, g.j1, g.j2, g.j3, g.x, g.y, g.hd, g.st);
            fails <= fails + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        solve_pose(cmd, joint1_angle, joint2_angle, joint3_angle, pos_x, pos_y, heading, p);
        awaited.push_back(p);
      end
    end
  end
endmodule

// ===== tb/sv/planar_three_link_kinematics_tb.sv =====
module planar_three_link_kinematics_tb;
  localparam logic [3:0] REG_LINK1 = 4'd0;
  localparam logic [3:0] REG_LINK2 = 4'd4;
  localparam logic [3:0] REG_LINK3 = 4'd8;
  localparam logic CMD_FWD = 1'b0;
  localparam logic CMD_INV = 1'b1;
  localparam int LATENCY = 106;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, cmd = 0;
  logic signed [15:0] joint1_angle = 0, joint2_angle = 0, joint3_angle = 0, heading = 0;
  logic signed [23:0] pos_x = 0, pos_y = 0;
  logic out_valid, out_ready = 0, status;
  logic signed [15:0] out_joint1, out_joint2, out_joint3, out_heading;
  logic signed [23:0] out_x, out_y;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  int fails, pending;
  bit calm = 0, hold_off = 0;

  always #5 clk = ~clk;

  planar_three_link_kinematics dut (.*);
  planar_three_link_kinematics_chk chk (.*);

  function automatic bit idle_now();
    return !calm && $urandom_range(99) < 38;
  endfunction

  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= !idle_now();
  end

  task automatic write_reg(input logic [3:0] a, input logic [31:0] d);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send(input logic c, input logic [15:0] a1, a2, a3,
                      input logic [23:0] x, y, input logic [15:0] h);
    while (idle_now()) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; cmd <= c;
    joint1_angle <= a1; joint2_angle <= a2; joint3_angle <= a3;
    pos_x <= x; pos_y <= y; heading <= h;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    logic [23:0] x, y;
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      send(CMD_FWD, 16'($urandom), 16'($urandom), 16'($urandom),
           24'($urandom), 24'($urandom), 16'($urandom));
    end else if (r < 85) begin
      x = 24'($signed($urandom_range(0, 120000)) - 60000);
      y = 24'($signed($urandom_range(0, 120000)) - 60000);
      send(CMD_INV, 16'($urandom), 16'($urandom), 16'($urandom), x, y, 16'($urandom));
    end else begin
      send(CMD_INV, 16'($urandom), 16'($urandom), 16'($urandom),
           24'($urandom), 24'($urandom), 16'($urandom));
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(CMD_FWD, 0, 0, 0, 0, 0, 0);
    send(CMD_FWD, 16'h7fff, 16'h8000, 16'h7fff, 0, 0, 0);
    send(CMD_FWD, 16'h8000, 16'h7fff, 16'h8000, 0, 0, 0);
    send(CMD_FWD, 16'h4000, 16'hffff, 16'hc000, 0, 0, 0);
    send(CMD_INV, 0, 0, 0, 24'd38400, 24'd0, 16'h0000);
    send(CMD_INV, 0, 0, 0, 24'd64000, 24'd0, 16'h0000);
    send(CMD_INV, 0, 0, 0, 24'd12800, 24'd0, 16'h0000);
    send(CMD_INV, 0, 0, 0, 24'd0, 24'd0, 16'h0000);
    send(CMD_INV, 0, 0, 0, 24'h7fffff, 24'h800000, 16'h7fff);
    send(CMD_INV, 0, 0, 0, 24'h800000, 24'h7fffff, 16'h8000);
    send(CMD_INV, 0, 0, 0, 24'd20000, -24'sd15000, 16'h2000);
    send(CMD_INV, 16'hffff, 16'hffff, 16'hffff, 24'd30000, 24'd9000, 16'hffff);
    drain();
    write_reg(REG_LINK1, 32'hfffff);
    write_reg(REG_LINK2, 32'hfffff);
    write_reg(REG_LINK3, 32'hfffff);
    send(CMD_FWD, 0, 0, 16'h8000, 0, 0, 0);
    send(CMD_FWD, 0, 16'h8000, 16'h8000, 0, 0, 0);
    send(CMD_INV, 0, 0, 0, 24'h7fffff, 24'h7fffff, 16'h2000);
    repeat (100) send_random();
    drain();
    write_reg(REG_LINK1, 0);
    write_reg(REG_LINK2, 32'd25600);
    write_reg(REG_LINK3, 0);
    send(CMD_INV, 0, 0, 0, 24'd25600, 0, 0);
    send(CMD_FWD, 16'h1234, 16'h5678, 16'h9abc, 0, 0, 0);
    repeat (40) send_random();
    drain();
    write_reg(REG_LINK1, 32'd30000);
    write_reg(REG_LINK2, 0);
    write_reg(REG_LINK3, 32'd5000);
    repeat (40) send_random();
    drain();
    write_reg(REG_LINK1, 32'd25600);
    write_reg(REG_LINK2, 32'd20000);
    write_reg(REG_LINK3, 32'd12800);
    calm = 1;
    repeat (80) send_random();
    calm = 0;
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      repeat (140) send_random();
    join
    drain();
    if (fails == 0) begin
      $display("planar_three_link_kinematics_tb: PASS");
    end else begin
      $display("planar_three_link_kinematics_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("planar_three_link_kinematics_tb: FAIL");
    $finish;
  end
endmodule
